// ===== sv/atanms_pkg.sv =====
// Shared types and constants for the arctangent series block.
package atanms_pkg;

	// Field and register widths
	localparam int WORD_W = 32;
	localparam int LAST_W = 10;
	localparam int DIVR_W = LAST_W + 1;
	localparam int TERM_W = WORD_W + 1;
	localparam int SUM_W  = WORD_W + LAST_W + 2;
	localparam int PROD_W = 2 * WORD_W;

	// Defaults
	localparam logic [LAST_W-1:0] LAST_INDEX_RESET = LAST_W'(500);
	localparam int MAX_INDEX_DEF = 1023;
	localparam int FRAC_BITS_DEF = 30;

	// Sequencer states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SQR  = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_ACC  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

endpackage

// ===== sv/atan_maclaurin_series_top.sv =====
// Arctangent by truncated Maclaurin series, one shared multiplier and a serial divider.
//
// Usage:
//  - Command channel: pulse start with x_value (signed Q2.30) while busy is low;
//    the item is taken at that edge and busy rises on the next cycle.
//  - Result: done is high for exactly one cycle with atan_sum, final_term and
//    out_of_range valid in that cycle. The receiver cannot stall; the result
//    must be captured then. busy drops the cycle after done.
//  - Config channel: cfg_valid/cfg_ready (always ready) writes last_index
//    from cfg_data; write it only while busy is low.
//  - Sequence for an in-range x with limit L = min(last_index, MAX_INDEX) >= 1:
//    x is squared on the shared multiplier; then each term takes a step on the
//    multiplier, a pass of the one-bit-per-cycle restoring divider and an
//    accumulate step, and the result state follows the last term.
//    Out-of-range x or L = 0: the block goes straight to the result state.
//  - One item at a time: start is ignored while busy is high.
//  - Reset (arst_n low) returns the sequencer to idle, clears done and
//    restores last_index to 500.
module atan_maclaurin_series_top #(
	parameter int MAX_INDEX = atanms_pkg::MAX_INDEX_DEF,
	parameter int FRAC_BITS = atanms_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [atanms_pkg::WORD_W-1:0] x_value,
	output logic                              done,
	output logic signed [atanms_pkg::WORD_W-1:0] atan_sum,
	output logic signed [atanms_pkg::WORD_W-1:0] final_term,
	output logic                              out_of_range,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [atanms_pkg::LAST_W-1:0]     cfg_data
);

	localparam int W   = atanms_pkg::WORD_W;
	localparam int LW  = atanms_pkg::LAST_W;
	localparam int DW  = atanms_pkg::DIVR_W;
	localparam int TW  = atanms_pkg::TERM_W;
	localparam int SW  = atanms_pkg::SUM_W;
	localparam int PW  = atanms_pkg::PROD_W;
	localparam int CW  = $clog2(W);
	localparam int CAP = (MAX_INDEX > (2 ** LW - 1)) ? (2 ** LW - 1) : MAX_INDEX;
	localparam logic [PW-1:0] ONE_L = PW'(1) << FRAC_BITS;
	localparam logic signed [SW-1:0] SAT_MAX = SW'((64'sd1 <<< (W - 1)) - 1);
	localparam logic signed [SW-1:0] SAT_MIN = -SW'(64'sd1 <<< (W - 1));
	localparam logic signed [TW-1:0] TSAT_MAX = TW'((64'sd1 <<< (W - 1)) - 1);

	atanms_pkg::state_t state_q;

	logic [LW-1:0]        last_index_q;
	logic [LW-1:0]        limit_q;
	logic [LW-1:0]        k_q;
	logic                 neg_q;
	logic                 oor_q;
	logic [W-1:0]         pw_q;
	logic [W-1:0]         x2_q;
	logic [W-1:0]         div_q;
	logic [DW-1:0]        rem_q;
	logic [CW-1:0]        cnt_q;
	logic signed [TW-1:0] term_q;
	logic signed [SW-1:0] sum_q;

	logic [W-1:0]         raw_mag;
	logic [LW-1:0]        limit_in;
	logic [W-1:0]         mul_b;
	logic [PW-1:0]        prod;
	logic [W-1:0]         prod_sh;
	logic [DW-1:0]        divisor;
	logic [DW:0]          div_sh;
	logic [DW+1:0]        div_diff;
	logic signed [TW-1:0] term_new;
	logic signed [TW-1:0] term_init;

	// Config register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_index_q <= atanms_pkg::LAST_INDEX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			last_index_q <= cfg_data;
		end
	end

	// Input magnitude and clamped last index
	assign raw_mag  = x_value[W-1] ? (~x_value + 1'b1) : x_value;
	assign limit_in = (int'(last_index_q) > CAP) ? LW'(CAP) : last_index_q;
	assign term_init = x_value[W-1] ? -$signed({1'b0, raw_mag}) : $signed({1'b0, raw_mag});

	// Shared multiplier: squares x in ST_SQR, advances the odd power in ST_MUL
	assign mul_b   = (state_q == atanms_pkg::ST_SQR) ? pw_q : x2_q;
	assign prod    = PW'(pw_q) * PW'(mul_b);
	assign prod_sh = W'(prod >> FRAC_BITS);

	// Restoring divider step, one quotient bit per cycle
	assign divisor  = {k_q, 1'b1};
	assign div_sh   = {rem_q, div_q[W-1]};
	assign div_diff = {1'b0, div_sh} - {2'b00, divisor};

	// Signed term from the quotient
	assign term_new = (neg_q ^ k_q[0]) ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

	// Sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= atanms_pkg::ST_IDLE;
		end else begin
			case (state_q)
				atanms_pkg::ST_IDLE: begin
					if (start) begin
						if ({{(PW-W){1'b0}}, raw_mag} > ONE_L) begin
							state_q <= atanms_pkg::ST_FIN;
						end else if (limit_in == '0) begin
							state_q <= atanms_pkg::ST_FIN;
						end else begin
							state_q <= atanms_pkg::ST_SQR;
						end
					end
				end
				atanms_pkg::ST_SQR: state_q <= atanms_pkg::ST_MUL;
				atanms_pkg::ST_MUL: state_q <= atanms_pkg::ST_DIV;
				atanms_pkg::ST_DIV: begin
					if (cnt_q == CW'(W - 1)) begin
						state_q <= atanms_pkg::ST_ACC;
					end
				end
				atanms_pkg::ST_ACC: begin
					if (k_q == limit_q) begin
						state_q <= atanms_pkg::ST_FIN;
					end else begin
						state_q <= atanms_pkg::ST_MUL;
					end
				end
				atanms_pkg::ST_FIN: state_q <= atanms_pkg::ST_IDLE;
				default: state_q <= atanms_pkg::ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			atanms_pkg::ST_IDLE: begin
				if (start) begin
					neg_q   <= x_value[W-1];
					pw_q    <= raw_mag;
					limit_q <= limit_in;
					k_q     <= '0;
					if ({{(PW-W){1'b0}}, raw_mag} > ONE_L) begin
						oor_q  <= 1'b1;
						sum_q  <= '0;
						term_q <= '0;
					end else begin
						oor_q  <= 1'b0;
						term_q <= term_init;
						sum_q  <= SW'(term_init);
					end
				end
			end
			atanms_pkg::ST_SQR: begin
				x2_q <= prod_sh;
				k_q  <= LW'(1);
			end
			atanms_pkg::ST_MUL: begin
				pw_q  <= prod_sh;
				div_q <= prod_sh;
				rem_q <= '0;
				cnt_q <= '0;
			end
			atanms_pkg::ST_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				if (!div_diff[DW+1]) begin
					rem_q <= div_diff[DW-1:0];
					div_q <= {div_q[W-2:0], 1'b1};
				end else begin
					rem_q <= div_sh[DW-1:0];
					div_q <= {div_q[W-2:0], 1'b0};
				end
			end
			atanms_pkg::ST_ACC: begin
				term_q <= term_new;
				sum_q  <= sum_q + SW'(term_new);
				if (k_q != limit_q) begin
					k_q <= k_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Outputs; atan_sum saturated to the word, final_term clamped only at the top
	assign busy         = (state_q != atanms_pkg::ST_IDLE);
	assign done         = (state_q == atanms_pkg::ST_FIN);
	assign out_of_range = oor_q;
	assign atan_sum     = (sum_q > SAT_MAX) ? W'(SAT_MAX) :
	                      (sum_q < SAT_MIN) ? W'(SAT_MIN) : W'(sum_q);
	assign final_term   = (term_q > TSAT_MAX) ? W'(TSAT_MAX) : W'(term_q);

endmodule

// ===== sv/atanms_checker.sv =====
// Port-level checks for the arctangent series block, bound to the top level.
module atanms_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic signed [atanms_pkg::WORD_W-1:0] atan_sum,
	input logic signed [atanms_pkg::WORD_W-1:0] final_term,
	input logic                              out_of_range
);

	// Result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// A taken item makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("item taken but busy not raised");

	// Results only appear while an item is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done without busy");

	// Out-of-range results carry zero sums
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_of_range) |-> (atan_sum == '0 && final_term == '0))
		else $error("out of range result with nonzero value");

	// busy only drops right after a result
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without a result");

endmodule

bind atan_maclaurin_series_top atanms_checker u_atanms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.atan_sum     (atan_sum),
	.final_term   (final_term),
	.out_of_range (out_of_range)
);
